FILE: hw/rtl/tbcc_pkg.sv
package tbcc_pkg;

    // Queue between the classifier and the walker
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;

    // Default internal coordinate width
    localparam int COORD_BITS_DEF = 16;

    // Item kinds on req_type
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // Unit vectors per heading, 0 north, clockwise in 45 degree steps
    localparam logic signed [1:0] STEP_DX [8] = '{2'sd0, 2'sd1, 2'sd1, 2'sd1,
                                                  2'sd0, -2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] STEP_DY [8] = '{2'sd1, 2'sd1, 2'sd0, -2'sd1,
                                                  -2'sd1, -2'sd1, 2'sd0, 2'sd1};

    // Classified word as it sits in the queue
    typedef struct packed {
        logic        is_start;
        logic        empty_rec;
        logic [7:0]  data;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [2:0]  dir;
        logic [7:0]  step;
        logic [15:0] count;
    } tbcc_item_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_BITS,
        BS_FINAL
    } tbcc_bstate_t;

endpackage

FILE: hw/rtl/turn_bit_chain_code_decoder_core.sv
// Channel   Direction  Handshake             Word
// --------  ---------  --------------------  ---------------------------------------------
// in        input      in_valid / in_stall   req_type, data_byte, start_x, start_y,
//                                            start_dir, step_len, bit_count
// out       output     out_valid / out_stall point_x, point_y, last_point
//
// A start word is taken by the walker in BS_IDLE; a data word is popped in BS_IDLE,
// its counted bits are walked in BS_BITS and the byte is closed in BS_FINAL. Data
// words with no open record are dropped.
// Reset is asynchronous, active low; it clears the queue, the walker and both
// vertex registers.
// out_stall backs up into the pending vertex, then the walker, then the
// 4-word queue; in_stall rises only when that queue is full.
module turn_bit_chain_code_decoder_core
    import tbcc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [7:0]         data_byte,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic [2:0]         start_dir,
    input  logic [7:0]         step_len,
    input  logic [15:0]        bit_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic               last_point
);

    // Classified words waiting for the walker
    logic       head_valid;
    tbcc_item_t head;
    logic       pop;

    // Front: accept, classify and queue words
    tbcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .data_byte  (data_byte),
        .start_x    (start_x),
        .start_y    (start_y),
        .start_dir  (start_dir),
        .step_len   (step_len),
        .bit_count  (bit_count),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Back: walk the turn bits one per cycle while out_stall allows, hold the newest vertex
    // until it is known whether it closes the record, then hand it to the output register
    tbcc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

endmodule

FILE: hw/rtl/tbcc_front.sv
module tbcc_front
    import tbcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [7:0]         data_byte,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic [2:0]         start_dir,
    input  logic [7:0]         step_len,
    input  logic [15:0]        bit_count,
    output logic               head_valid,
    output tbcc_item_t         head,
    input  logic               pop
);

    tbcc_item_t             q_reg [QDEPTH];
    logic [QPTR_BITS-1:0]   wr_reg, wr_next;
    logic [QPTR_BITS-1:0]   rd_reg, rd_next;
    logic [QPTR_BITS:0]     cnt_reg, cnt_next;
    tbcc_item_t             item;
    logic                   push;
    logic                   do_pop;

    // Classify the incoming word
    always_comb
    begin
        item           = '0;
        item.is_start  = (req_type == REQ_START);
        item.empty_rec = (req_type == REQ_START) && (bit_count == 16'd0);
        item.data      = data_byte;
        item.sx        = start_x;
        item.sy        = start_y;
        item.dir       = start_dir;
        item.step      = step_len;
        item.count     = bit_count;
    end

    assign in_stall   = (cnt_reg == (QPTR_BITS+1)'(QDEPTH));
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = q_reg[rd_reg];

    always_comb
    begin
        wr_next  = push   ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= item;
        end
    end

endmodule

FILE: hw/rtl/tbcc_back.sv
module tbcc_back
    import tbcc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  tbcc_item_t         head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] point_x,
    output logic signed [15:0] point_y,
    output logic               last_point
);

    localparam int CB = COORD_BITS;
    localparam int W  = ((CB > 16) ? CB : 16) + 2;
    localparam logic signed [W-1:0] CHI = {{(W-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [W-1:0] CLO = {{(W-CB+1){1'b1}}, {(CB-1){1'b0}}};

    function automatic logic signed [CB-1:0] sat_c(input logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        r = v;
        if (v > CHI)
        begin
            r = CHI;
        end
        else if (v < CLO)
        begin
            r = CLO;
        end
        return r[CB-1:0];
    endfunction

    function automatic logic signed [W-1:0] ext_c(input logic signed [CB-1:0] v);
        return {{(W-CB){v[CB-1]}}, v};
    endfunction

    function automatic logic [15:0] low16(input logic signed [CB-1:0] v);
        logic [W-1:0] t;
        t = ext_c(v);
        return t[15:0];
    endfunction

    function automatic logic signed [W-1:0] move(input logic signed [CB-1:0] p,
                                                 input logic signed [1:0]   d,
                                                 input logic [7:0]          s);
        logic signed [W-1:0] pw;
        logic signed [W-1:0] sw;
        logic signed [W-1:0] r;
        pw = ext_c(p);
        sw = {{(W-8){1'b0}}, s};
        r  = pw;
        if (d == 2'sd1)
        begin
            r = pw + sw;
        end
        else if (d == -2'sd1)
        begin
            r = pw - sw;
        end
        return r;
    endfunction

    // Walker state
    tbcc_bstate_t          state_reg, state_next;
    logic signed [CB-1:0]  pos_x_reg, pos_x_next;
    logic signed [CB-1:0]  pos_y_reg, pos_y_next;
    logic signed [CB-1:0]  emit_x_reg, emit_x_next;
    logic signed [CB-1:0]  emit_y_reg, emit_y_next;
    logic [2:0]            head_reg, head_next;
    logic [2:0]            lhead_reg, lhead_next;
    logic [15:0]           left_reg, left_next;
    logic [7:0]            step_reg, step_next;
    logic [7:0]            byte_reg, byte_next;
    logic [2:0]            idx_reg, idx_next;
    logic                  vbyte_reg, vbyte_next;

    // Pending vertex: may still take the last mark
    logic                  pv_reg, pv_next;
    logic                  prdy_reg, prdy_next;
    logic [15:0]           px_reg, px_next;
    logic [15:0]           py_reg, py_next;
    logic                  pl_reg, pl_next;

    // Output register
    logic                  ov_reg, ov_next;
    logic [15:0]           ox_reg, ox_next;
    logic [15:0]           oy_reg, oy_next;
    logic                  ol_reg, ol_next;

    // Vertex request of this cycle
    logic                  vreq;
    logic [15:0]           vx, vy;
    logic                  vl, vrdy;
    logic                  mark_last, mark_rdy;

    logic signed [CB-1:0]  nx, ny;
    logic signed [CB-1:0]  sx, sy;
    logic                  cur_bit;
    logic                  turn_emit;
    logic                  out_free, pend_move, slot_ok, advance;

    assign nx        = sat_c(move(pos_x_reg, STEP_DX[head_reg], step_reg));
    assign ny        = sat_c(move(pos_y_reg, STEP_DY[head_reg], step_reg));
    assign sx        = sat_c({{(W-16){head.sx[15]}}, head.sx});
    assign sy        = sat_c({{(W-16){head.sy[15]}}, head.sy});
    assign cur_bit   = byte_reg[idx_reg];
    assign turn_emit = cur_bit && (head_reg != lhead_reg);

    always_comb
    begin
        vreq      = 1'b0;
        vx        = low16(pos_x_reg);
        vy        = low16(pos_y_reg);
        vl        = 1'b0;
        vrdy      = 1'b0;
        mark_last = 1'b0;
        mark_rdy  = 1'b0;
        case (state_reg)
            BS_IDLE:
            begin
                if (head_valid && head.is_start)
                begin
                    vreq = 1'b1;
                    vx   = low16(sx);
                    vy   = low16(sy);
                    vl   = head.empty_rec;
                    vrdy = 1'b1;
                end
            end
            BS_BITS:
            begin
                if (turn_emit)
                begin
                    vreq = 1'b1;
                    vx   = low16(nx);
                    vy   = low16(ny);
                end
            end
            BS_FINAL:
            begin
                mark_rdy = 1'b1;
                if (left_reg == 16'd0)
                begin
                    if ((pos_x_reg != emit_x_reg) || (pos_y_reg != emit_y_reg) || !vbyte_reg)
                    begin
                        vreq = 1'b1;
                        vl   = 1'b1;
                        vrdy = 1'b1;
                    end
                    else
                    begin
                        mark_last = 1'b1;
                    end
                end
            end
            default:
            begin
                vreq = 1'b0;
            end
        endcase
    end

    assign out_free  = !ov_reg || !out_stall;
    assign pend_move = pv_reg && (prdy_reg || vreq) && out_free;
    assign slot_ok   = !pv_reg || pend_move;
    assign advance   = !vreq || slot_ok;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (head_valid && !head.is_start && (left_reg != 16'd0))
                begin
                    state_next = BS_BITS;
                end
            end
            BS_BITS:
            begin
                if (advance && ((idx_reg == 3'd0) || (left_reg == 16'd1)))
                begin
                    state_next = BS_FINAL;
                end
            end
            BS_FINAL:
            begin
                if (advance)
                begin
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Walker datapath and queue pop
    always_comb
    begin
        pop         = 1'b0;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        emit_x_next = emit_x_reg;
        emit_y_next = emit_y_reg;
        head_next   = head_reg;
        lhead_next  = lhead_reg;
        left_next   = left_reg;
        step_next   = step_reg;
        byte_next   = byte_reg;
        idx_next    = idx_reg;
        vbyte_next  = vbyte_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (head_valid && head.is_start)
                begin
                    if (advance)
                    begin
                        pop         = 1'b1;
                        pos_x_next  = sx;
                        pos_y_next  = sy;
                        emit_x_next = sx;
                        emit_y_next = sy;
                        head_next   = head.dir;
                        lhead_next  = head.dir;
                        step_next   = head.step;
                        left_next   = head.count;
                    end
                end
                else if (head_valid)
                begin
                    // Pop data words; a byte is walked only when a record is open, else it is dropped
                    pop        = 1'b1;
                    byte_next  = head.data;
                    idx_next   = 3'd7;
                    vbyte_next = 1'b0;
                end
            end
            BS_BITS:
            begin
                if (advance)
                begin
                    pos_x_next = nx;
                    pos_y_next = ny;
                    left_next  = left_reg - 16'd1;
                    idx_next   = idx_reg - 3'd1;
                    if (cur_bit)
                    begin
                        if (turn_emit)
                        begin
                            emit_x_next = nx;
                            emit_y_next = ny;
                            lhead_next  = head_reg;
                            vbyte_next  = 1'b1;
                        end
                        // Odd bit positions turn counter-clockwise
                        head_next = idx_reg[0] ? head_reg - 3'd1 : head_reg + 3'd1;
                    end
                end
            end
            BS_FINAL:
            begin
                if (advance && vreq)
                begin
                    emit_x_next = pos_x_reg;
                    emit_y_next = pos_y_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Pending slot and output register
    always_comb
    begin
        pv_next   = pv_reg;
        prdy_next = prdy_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        pl_next   = pl_reg;
        ov_next   = ov_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        ol_next   = ol_reg;
        if (out_free)
        begin
            ov_next = pend_move;
            ox_next = px_reg;
            oy_next = py_reg;
            ol_next = pl_reg;
        end
        if (pend_move)
        begin
            pv_next = 1'b0;
        end
        if (advance && mark_rdy)
        begin
            prdy_next = 1'b1;
        end
        if (advance && mark_last)
        begin
            pl_next = 1'b1;
        end
        if (vreq && advance)
        begin
            pv_next   = 1'b1;
            prdy_next = vrdy;
            px_next   = vx;
            py_next   = vy;
            pl_next   = vl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BS_IDLE;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            emit_x_reg <= '0;
            emit_y_reg <= '0;
            head_reg   <= '0;
            lhead_reg  <= '0;
            left_reg   <= '0;
            step_reg   <= '0;
            idx_reg    <= '0;
            vbyte_reg  <= 1'b0;
            pv_reg     <= 1'b0;
            prdy_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            emit_x_reg <= emit_x_next;
            emit_y_reg <= emit_y_next;
            head_reg   <= head_next;
            lhead_reg  <= lhead_next;
            left_reg   <= left_next;
            step_reg   <= step_next;
            idx_reg    <= idx_next;
            vbyte_reg  <= vbyte_next;
            pv_reg     <= pv_next;
            prdy_reg   <= prdy_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pl_reg   <= pl_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        ol_reg   <= ol_next;
    end

    assign out_valid  = ov_reg;
    assign point_x    = ox_reg;
    assign point_y    = oy_reg;
    assign last_point = ol_reg;

endmodule
